### src/panama_push_pull_core_assert.svh
// assertion macros for the checker file
// every macro samples on i_clk and is switched off while i_rst_n is low
`ifndef PANAMA_PUSH_PULL_CORE_ASSERT_SVH
`define PANAMA_PUSH_PULL_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/ppc_pkg.sv
// ---------------------------------------------------------------------------
// ppc_pkg
// types, constants and the round function of the panama push/pull core
// ---------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

    localparam int BUFFER_STAGES = 32;
    localparam int STAGE_WORDS   = 8;
    localparam int CORE_LEN      = 17;
    localparam int WORD_BITS     = 32;

    // buffer taps, in logical stages
    localparam int TAP_LAMBDA   = 4;
    localparam int TAP_BETA     = 16;
    localparam int TAP_FEEDBACK = 25;
    localparam int FEED_ROT     = 2;

    localparam logic [WORD_BITS-1:0] CORE_IV = 32'h0000_0001;

    typedef logic [WORD_BITS-1:0]                    t_word;
    typedef logic [STAGE_WORDS-1:0][WORD_BITS-1:0]   t_stage;
    typedef logic [CORE_LEN-1:0][WORD_BITS-1:0]      t_core;

    typedef enum logic [1:0] {
        KIND_CLEAR      = 2'd0,
        KIND_PUSH       = 2'd1,
        KIND_PULL_OUT   = 2'd2,
        KIND_PULL_BLANK = 2'd3
    } t_kind;

    typedef struct packed {
        logic round;
        logic clear;
    } t_ctrl;

    // pi permutation: source word and rotate amount per destination word
    localparam int PI_SRC [CORE_LEN] = '{0, 7, 14, 4, 11, 1, 8, 15, 5,
                                         12, 2, 9, 16, 6, 13, 3, 10};
    localparam int PI_ROT [CORE_LEN] = '{0, 1, 3, 6, 10, 15, 21, 28, 4,
                                         13, 23, 2, 14, 27, 9, 24, 8};

    function automatic t_word ppc_rotl(input t_word x, input int unsigned s);
        return (x << s) | (x >> (WORD_BITS - s));
    endfunction

    // gamma, pi, theta
    function automatic t_core ppc_mix(input t_core a);
        t_core g;
        t_core p;
        t_core t;
        for (int i = 0; i < CORE_LEN; i++) begin
            g[i] = a[i] ^ (a[(i + 1) % CORE_LEN] | ~a[(i + 2) % CORE_LEN]);
        end
        for (int i = 0; i < CORE_LEN; i++) begin
            p[i] = ppc_rotl(g[PI_SRC[i]], PI_ROT[i]);
        end
        for (int i = 0; i < CORE_LEN; i++) begin
            t[i] = p[i] ^ p[(i + 1) % CORE_LEN] ^ p[(i + 4) % CORE_LEN];
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### src/ppc_stage_cell.sv
// ---------------------------------------------------------------------------
// ppc_stage_cell
// one eight-word stage of the buffer shift chain
// ---------------------------------------------------------------------------
`default_nettype none

module ppc_stage_cell
    import ppc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_ctrl  i_ctrl,
    input  wire t_stage i_prev,
    input  wire t_stage i_inj,
    output t_stage      o_stage
);

    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        n_stage = r_stage;
        if (i_ctrl.clear) begin
            n_stage = '0;
        end else if (i_ctrl.round) begin
            n_stage = i_prev ^ i_inj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

### src/ppc_core.sv
// ---------------------------------------------------------------------------
// ppc_core
// 17-word state register and its round update
// ---------------------------------------------------------------------------
`default_nettype none

module ppc_core
    import ppc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_ctrl  i_ctrl,
    input  wire t_stage i_lin,
    input  wire t_stage i_bin,
    output t_core       o_core
);

    t_core r_core;
    t_core n_core;
    t_core w_mix;

    assign w_mix = ppc_mix(r_core);

    always_comb begin
        n_core = r_core;
        if (i_ctrl.clear) begin
            n_core = '0;
        end else if (i_ctrl.round) begin
            n_core[0] = w_mix[0] ^ CORE_IV;
            for (int j = 0; j < STAGE_WORDS; j++) begin
                n_core[j + 1] = w_mix[j + 1] ^ i_lin[j];
                n_core[j + 1 + STAGE_WORDS] = w_mix[j + 1 + STAGE_WORDS] ^ i_bin[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= '0;
        end else begin
            r_core <= n_core;
        end
    end

    assign o_core = r_core;

endmodule

`default_nettype wire

### src/panama_push_pull_core.sv
// ---------------------------------------------------------------------------
// panama_push_pull_core
// panama round engine: 17-word state plus a 32-stage buffer shift chain
// ---------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) carries one operation per transfer:
//   clear, push of an eight-word block, pull with output, or blank pull
//   output channel (o_out_valid / i_out_ready) carries the eight keystream
//   words of a pull with output, four 64-bit ports, low word low
//   every operation completes in the cycle of its transfer, so one item is
//   taken per clock while o_in_ready is high; the round is a single layer of
//   gamma/pi/theta logic and the buffer is a chain of stage cells that all
//   shift together; a pull result is registered in the main output register,
//   or in the skid register while the main one stalls; o_in_ready only
//   drops while both hold a result, i.e. after the receiver stalls two
//   results; items without a result still need a free skid slot to enter
//   reset (synchronous, active low) clears state, buffer and both output
//   slots; a clear item does the same to state and buffer only
//   a stalled result holds its value until the receiver takes it
// ---------------------------------------------------------------------------
`default_nettype none

module panama_push_pull_core
    import ppc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // operation channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_data_w10,
    input  wire logic [63:0] i_data_w32,
    input  wire logic [63:0] i_data_w54,
    input  wire logic [63:0] i_data_w76,
    // keystream channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_out_w10,
    output logic [63:0]      o_out_w32,
    output logic [63:0]      o_out_w54,
    output logic [63:0]      o_out_w76
);

    typedef logic [3:0][63:0] t_result;

    // buffer chain: w_stage[i] is logical stage i
    t_stage w_stage [BUFFER_STAGES];
    t_stage w_inj   [BUFFER_STAGES];

    t_core   w_core;
    t_ctrl   w_ctrl;
    t_stage  w_blk;
    t_stage  w_q;
    t_stage  w_lin;
    t_stage  w_fb;
    t_result w_res;
    logic    w_take;
    logic    w_emit;

    // output slots
    logic    r_ov;
    logic    r_sv;
    t_result r_od;
    t_result r_sd;
    logic    n_ov;
    logic    n_sv;
    t_result n_od;
    t_result n_sd;

    assign w_take = i_in_valid && o_in_ready;

    // unpack the block, word 0 in the low half of data_w10
    assign w_blk = {i_data_w76, i_data_w54, i_data_w32, i_data_w10};

    // keystream: block xor state words 9..16, taken before the round
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_res[j] = {w_blk[2 * j + 1] ^ w_core[2 * j + 1 + STAGE_WORDS + 1],
                        w_blk[2 * j] ^ w_core[2 * j + STAGE_WORDS + 1]};
        end
    end

    // operation decode
    always_comb begin
        w_ctrl = '0;
        w_emit = 1'b0;
        w_q    = w_blk;
        w_lin  = w_blk;
        unique case (t_kind'(i_kind))
            KIND_CLEAR: begin
                w_ctrl.clear = w_take;
            end
            KIND_PUSH: begin
                w_ctrl.round = w_take;
            end
            KIND_PULL_OUT, KIND_PULL_BLANK: begin
                w_ctrl.round = w_take;
                w_emit       = w_take && (t_kind'(i_kind) == KIND_PULL_OUT);
                for (int j = 0; j < STAGE_WORDS; j++) begin
                    w_q[j] = w_core[j + 1];
                end
                w_lin = w_stage[TAP_LAMBDA];
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    // lfsr feedback: old last stage rotated by two words into new stage 25
    always_comb begin
        for (int j = 0; j < STAGE_WORDS; j++) begin
            w_fb[j] = w_stage[BUFFER_STAGES - 1][(j + FEED_ROT) % STAGE_WORDS];
        end
        for (int s = 0; s < BUFFER_STAGES; s++) begin
            w_inj[s] = '0;
        end
        w_inj[0]            = w_q;
        w_inj[TAP_FEEDBACK] = w_fb;
    end

    ppc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_lin   (w_lin),
        .i_bin   (w_stage[TAP_BETA]),
        .o_core  (w_core)
    );

    // cell s takes cell s-1 each round; cell 0 wraps from the last cell
    for (genvar s = 0; s < BUFFER_STAGES; s++) begin : g_cell
        ppc_stage_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_stage[(s + BUFFER_STAGES - 1) % BUFFER_STAGES]),
            .i_inj   (w_inj[s]),
            .o_stage (w_stage[s])
        );
    end

    // output register with skid slot
    always_comb begin
        n_ov = r_ov;
        n_sv = r_sv;
        n_od = r_od;
        n_sd = r_sd;
        if (r_ov && !i_out_ready) begin
            // main slot stalled, park a new result in the skid slot
            if (w_emit) begin
                n_sv = 1'b1;
                n_sd = w_res;
            end
        end else begin
            if (r_sv) begin
                n_ov = 1'b1;
                n_od = r_sd;
                n_sv = 1'b0;
            end else if (w_emit) begin
                n_ov = 1'b1;
                n_od = w_res;
            end else begin
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign o_in_ready  = !r_sv;
    assign o_out_valid = r_ov;
    assign o_out_w10   = r_od[0];
    assign o_out_w32   = r_od[1];
    assign o_out_w54   = r_od[2];
    assign o_out_w76   = r_od[3];

endmodule

`default_nettype wire

### src/ppc_checker.sv
// ---------------------------------------------------------------------------
// ppc_checker
// port-level checks of the panama push/pull core, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "panama_push_pull_core_assert.svh"

module ppc_checker
    import ppc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [1:0]  i_kind,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_out_w10,
    input wire logic [63:0] o_out_w32,
    input wire logic [63:0] o_out_w54,
    input wire logic [63:0] o_out_w76
);

    logic         w_pull_out;
    logic         w_stall;
    logic [255:0] w_out_bus;

    assign w_pull_out = i_in_valid && o_in_ready && (i_kind == KIND_PULL_OUT);
    assign w_stall    = o_out_valid && !i_out_ready;
    assign w_out_bus  = {o_out_w76, o_out_w54, o_out_w32, o_out_w10};

    // stalled result holds
    `PPC_ASSERT_NEXT(a_out_hold, w_stall, o_out_valid && $stable(w_out_bus), "stall changed data")

    // a pull into an empty output shows up next cycle
    `PPC_ASSERT_NEXT(a_pull_lat, w_pull_out && !o_out_valid, o_out_valid, "pull result missing")

    // a result only appears after a pull with output
    `PPC_ASSERT_NOW(a_no_ghost, $rose(o_out_valid), $past(w_pull_out), "result without pull")

    // input side only backs up while a result is waiting
    `PPC_ASSERT_NOW(a_ready_low, !o_in_ready, o_out_valid, "ready low with empty output")

endmodule

bind panama_push_pull_core ppc_checker u_ppc_checker (.*);

`default_nettype wire

### dv/panama_push_pull_core_tb.sv
// ---------------------------------------------------------------------------
// panama_push_pull_core_tb
// checks the panama round engine against a cycle-free model of its state
// ---------------------------------------------------------------------------
// every operation accepted on the input channel is applied to a local copy of
// the core, the 32-stage buffer and the tap pointer; a pull with output
// queues the eight keystream words it must produce, and each transfer on the
// output channel is compared port by port with the oldest queued words
// stimulus: directed extremes, ignored data on clear and blank pull, a long
// receiver stall that fills the output slots, then random traffic mixing
// single operations with complete absorb / blank-round / squeeze sequences
// ---------------------------------------------------------------------------

module panama_push_pull_core_tb
    import ppc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 700;
    localparam int BLANK_ROUNDS   = 32;    // blank pulls between absorb and squeeze
    localparam int GAP_LIMIT      = 17;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int REPORT_LIMIT   = 10;

    // dut ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [63:0] i_data_w10;
    logic [63:0] i_data_w32;
    logic [63:0] i_data_w54;
    logic [63:0] i_data_w76;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_out_w10;
    logic [63:0] o_out_w32;
    logic [63:0] o_out_w54;
    logic [63:0] o_out_w76;

    // model state: core words, buffer stages by physical index, tap pointer
    t_word       core_st [CORE_LEN];
    t_stage      ring_st [BUFFER_STAGES];
    logic [4:0]  tap_pos;

    // keystream blocks still owed by the dut, oldest first
    t_stage      keystream_due [$];

    int          mismatch_count;
    int          in_gap_max;     // per-item idle draw limit on the input side
    int          out_gap_max;    // per-result stall draw limit on the output side
    int          hold_len;       // one-shot long stall request for the receiver
    int          items_sent;

    panama_push_pull_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_data_w10  (i_data_w10),
        .i_data_w32  (i_data_w32),
        .i_data_w54  (i_data_w54),
        .i_data_w76  (i_data_w76),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_w10   (o_out_w10),
        .o_out_w32   (o_out_w32),
        .o_out_w54   (o_out_w54),
        .o_out_w76   (o_out_w76)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // model of the round engine
    // -----------------------------------------------------------------------

    function automatic t_word rot_left(input t_word x, input int s);
        logic [63:0] twice;
        twice = {x, x} << s;
        return twice[63:32];
    endfunction

    function automatic void wipe_state();
        for (int i = 0; i < CORE_LEN; i++) begin
            core_st[i] = '0;
        end
        for (int s = 0; s < BUFFER_STAGES; s++) begin
            ring_st[s] = '0;
        end
        tap_pos = '0;
    endfunction

    // gamma, pi, theta on the core, then the buffer lfsr step fed with q,
    // then the core picks up lambda words (1..8) and beta words (9..16)
    function automatic void panama_round(input t_stage q, input t_stage lam,
                                         input t_stage bet);
        t_word      gam   [CORE_LEN];
        t_word      perm  [CORE_LEN];
        t_word      mixed [CORE_LEN];
        int         tri_n;
        logic [4:0] head;
        logic [4:0] fb;
        for (int i = 0; i < CORE_LEN; i++) begin
            gam[i] = core_st[i] ^ (core_st[(i + 1) % CORE_LEN]
                                   | ~core_st[(i + 2) % CORE_LEN]);
        end
        for (int i = 0; i < CORE_LEN; i++) begin
            tri_n   = (i * (i + 1) / 2) % WORD_BITS;
            perm[i] = rot_left(gam[(7 * i) % CORE_LEN], tri_n);
        end
        for (int i = 0; i < CORE_LEN; i++) begin
            mixed[i] = perm[i] ^ perm[(i + 1) % CORE_LEN] ^ perm[(i + 4) % CORE_LEN];
        end
        // the new stage 0 sits one below the old one
        head = tap_pos - 5'd1;
        fb   = 5'(head + TAP_FEEDBACK);
        for (int j = 0; j < STAGE_WORDS; j++) begin
            ring_st[fb][j] = ring_st[fb][j]
                             ^ ring_st[head][(j + FEED_ROT) % STAGE_WORDS];
        end
        ring_st[head] = ring_st[head] ^ q;
        tap_pos = head;
        core_st[0] = mixed[0] ^ CORE_IV;
        for (int j = 1; j <= STAGE_WORDS; j++) begin
            core_st[j] = mixed[j] ^ lam[j - 1];
        end
        for (int j = STAGE_WORDS + 1; j < CORE_LEN; j++) begin
            core_st[j] = mixed[j] ^ bet[j - STAGE_WORDS - 1];
        end
    endfunction

    // applies one accepted operation, queuing keystream for a pull with output
    function automatic void panama_advance(input t_kind kind, input t_stage blk);
        t_stage lam;
        t_stage bet;
        t_stage q;
        t_stage ks;
        bet = ring_st[5'(tap_pos + TAP_BETA)];
        lam = ring_st[5'(tap_pos + TAP_LAMBDA)];
        case (kind)
            KIND_CLEAR: begin
                wipe_state();
            end
            KIND_PUSH: begin
                panama_round(blk, blk, bet);
            end
            default: begin
                if (kind == KIND_PULL_OUT) begin
                    for (int j = 0; j < STAGE_WORDS; j++) begin
                        ks[j] = blk[j] ^ core_st[STAGE_WORDS + 1 + j];
                    end
                    keystream_due.push_back(ks);
                end
                for (int j = 0; j < STAGE_WORDS; j++) begin
                    q[j] = core_st[j + 1];
                end
                panama_round(q, lam, bet);
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // result checking
    // -----------------------------------------------------------------------

    function automatic void flag_mismatch(input string port, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected %016h, actual %016h", $time, port, want, got);
        end
    endfunction

    function automatic void check_keystream();
        t_stage want;
        if (keystream_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("[%0t] keystream transfer with none pending: %016h %016h %016h %016h",
                         $time, o_out_w76, o_out_w54, o_out_w32, o_out_w10);
            end
            return;
        end
        want = keystream_due.pop_front();
        if (o_out_w10 !== want[1:0]) flag_mismatch("o_out_w10", want[1:0], o_out_w10);
        if (o_out_w32 !== want[3:2]) flag_mismatch("o_out_w32", want[3:2], o_out_w32);
        if (o_out_w54 !== want[5:4]) flag_mismatch("o_out_w54", want[5:4], o_out_w54);
        if (o_out_w76 !== want[7:6]) flag_mismatch("o_out_w76", want[7:6], o_out_w76);
    endfunction

    // sample both channels at the edge; results are checked before the
    // operation of the same edge is applied, though no result can depend on it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                check_keystream();
            end
            if (i_in_valid && o_in_ready) begin
                panama_advance(t_kind'(i_kind),
                               t_stage'({i_data_w76, i_data_w54, i_data_w32, i_data_w10}));
            end
        end
    end

    // -----------------------------------------------------------------------
    // receiver: random stall before each result, plus one-shot long holds
    // -----------------------------------------------------------------------
    initial begin : receiver
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end else begin
                stall = $urandom_range(out_gap_max, 0);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // -----------------------------------------------------------------------
    // sender
    // -----------------------------------------------------------------------

    function automatic logic [63:0] rand_dword();
        case ($urandom_range(15, 0))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // offers one operation and returns at the edge of its transfer; valid stays
    // high when the next item follows with no idle cycles
    task automatic send_op(input t_kind kind, input logic [63:0] d10,
                           input logic [63:0] d32, input logic [63:0] d54,
                           input logic [63:0] d76);
        int gap;
        gap = $urandom_range(in_gap_max, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_data_w10 <= d10;
        i_data_w32 <= d32;
        i_data_w54 <= d54;
        i_data_w76 <= d76;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_random_data(input t_kind kind);
        send_op(kind, rand_dword(), rand_dword(), rand_dword(), rand_dword());
    endtask

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------

    // keystream straight out of reset is the data itself, then all-ones data
    task automatic test_pull_after_reset();
        send_op(KIND_PULL_OUT, '0, '0, '0, '0);
        send_op(KIND_PULL_OUT, '1, '1, '1, '1);
        send_random_data(KIND_PULL_BLANK);
        send_op(KIND_PULL_OUT, '1, '0, '1, '0);
    endtask

    // pushes of extreme blocks, with pulls reading back their effect
    task automatic test_block_extremes();
        send_op(KIND_PUSH, '0, '0, '0, '0);
        send_op(KIND_PULL_OUT, '0, '0, '0, '0);
        send_op(KIND_PUSH, '1, '1, '1, '1);
        send_op(KIND_PULL_OUT, '1, '1, '1, '1);
        send_op(KIND_PUSH, {4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}});
        send_op(KIND_PUSH, {4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}});
        send_op(KIND_PULL_OUT, {4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}},
                {4{16'h5555}});
        send_op(KIND_PULL_OUT, {4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}},
                {4{16'haaaa}});
    endtask

    // clear and blank pull take data that must have no effect
    task automatic test_ignored_data();
        send_random_data(KIND_PUSH);
        send_op(KIND_PULL_BLANK, '1, '1, '1, '1);
        send_random_data(KIND_PULL_BLANK);
        send_random_data(KIND_PULL_OUT);
        send_op(KIND_CLEAR, '1, '1, '1, '1);
        send_op(KIND_PULL_OUT, '0, '0, '0, '0);
        send_random_data(KIND_PUSH);
        send_random_data(KIND_CLEAR);
        send_random_data(KIND_PULL_OUT);
    endtask

    // receiver holds off long enough for both output slots to fill and the
    // input channel to stall while pulls keep being offered back to back
    task automatic test_output_backpressure();
        in_gap_max  = 0;
        out_gap_max = 0;
        hold_len    = HOLD_CYCLES;
        for (int n = 0; n < 24; n++) begin
            send_random_data((n % 3 == 2) ? KIND_PUSH : KIND_PULL_OUT);
        end
    endtask

    // a hash-style run: clear, absorb blocks, blank rounds, then squeeze
    task automatic send_hash_sequence();
        int pushes;
        int pulls;
        pushes = $urandom_range(4, 1);
        pulls  = $urandom_range(4, 1);
        send_random_data(KIND_CLEAR);
        repeat (pushes) send_random_data(KIND_PUSH);
        repeat (BLANK_ROUNDS) send_random_data(KIND_PULL_BLANK);
        repeat (pulls) send_random_data(KIND_PULL_OUT);
    endtask

    task automatic test_random_traffic();
        int start;
        int pick;
        int next_regap;
        start      = items_sent;
        next_regap = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            // new idle profile every few dozen items, including stretches
            // where neither side idles
            if (items_sent >= next_regap) begin
                case ($urandom_range(3, 0))
                    0:       begin in_gap_max = 0;         out_gap_max = 0;         end
                    1:       begin in_gap_max = GAP_LIMIT; out_gap_max = 0;         end
                    2:       begin in_gap_max = 0;         out_gap_max = GAP_LIMIT; end
                    default: begin in_gap_max = GAP_LIMIT; out_gap_max = GAP_LIMIT; end
                endcase
                next_regap = items_sent + $urandom_range(60, 20);
            end
            pick = $urandom_range(99, 0);
            if (pick < 4) begin
                send_hash_sequence();
            end else if (pick < 7) begin
                send_random_data(KIND_CLEAR);
            end else if (pick < 45) begin
                send_random_data(KIND_PUSH);
            end else if (pick < 80) begin
                send_random_data(KIND_PULL_OUT);
            end else begin
                send_random_data(KIND_PULL_BLANK);
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin : run
        int waited;
        mismatch_count = 0;
        items_sent     = 0;
        hold_len       = 0;
        in_gap_max     = GAP_LIMIT;
        out_gap_max    = GAP_LIMIT;
        wipe_state();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind     <= KIND_CLEAR;
        i_data_w10 <= '0;
        i_data_w32 <= '0;
        i_data_w54 <= '0;
        i_data_w76 <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pull_after_reset();
        test_block_extremes();
        test_ignored_data();
        test_output_backpressure();
        in_gap_max  = GAP_LIMIT;
        out_gap_max = GAP_LIMIT;
        test_random_traffic();

        // stop offering, let the receiver take everything still owed
        i_in_valid  <= 1'b0;
        out_gap_max = 0;
        waited      = 0;
        while (keystream_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && keystream_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // generous bound: far above the slowest correct run of this stimulus
    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
